[hw/rtl/skf_pkg.sv]
// shared types and constants for the scalar kalman filter
package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = DATA_W + 1 + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;
  localparam logic [DATA_W-1:0] R_RESET  = DATA_W'(1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_div_stat_t;

endpackage

[hw/rtl/skf_in_if.sv]
// sample channel: valid/ready with sample and restart flag
interface skf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [skf_pkg::DATA_W-1:0]     sample;
  logic                                  restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

[hw/rtl/skf_out_if.sv]
// result channel: valid/ready with estimate and gain
interface skf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [skf_pkg::DATA_W-1:0]     estimate;
  logic [skf_pkg::GAIN_W-1:0]            gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink (input valid, input estimate, input gain, output ready);
endinterface

[hw/rtl/skf_div.sv]
// restoring divider for the gain p / (p + r) as a q1.16 fraction
module skf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [skf_pkg::DATA_W-1:0]    num,
  input  logic [skf_pkg::DATA_W-1:0]    noise,
  output skf_pkg::skf_div_stat_t        stat,
  output logic [skf_pkg::GAIN_W-1:0]    quot
);

  localparam int CNT_W = $clog2(skf_pkg::GAIN_W);

  logic [skf_pkg::DATA_W:0]     den;
  logic [skf_pkg::DATA_W:0]     rem;
  logic [skf_pkg::GAIN_W-1:0]   q;
  logic [CNT_W-1:0]             cnt;
  logic                         lsb;
  logic                         busy;
  logic                         done;

  logic                         bit_in;
  logic [skf_pkg::DATA_W+1:0]   trial;
  logic [skf_pkg::DATA_W+1:0]   diff;
  logic                         ge;

  // numerator is num << 16, so only its lowest bit ever shifts in
  assign bit_in = (cnt == CNT_W'(skf_pkg::GAIN_W - 1)) ? lsb : 1'b0;
  assign trial  = {rem, bit_in};
  assign diff   = trial - {1'b0, den};
  assign ge     = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= {1'b0, num} + {1'b0, noise};
      rem <= {2'b00, num[skf_pkg::DATA_W-1:1]};
      lsb <= num[0];
      q   <= '0;
      cnt <= CNT_W'(skf_pkg::GAIN_W - 1);
    end else if (busy) begin
      rem <= ge ? diff[skf_pkg::DATA_W:0] : trial[skf_pkg::DATA_W:0];
      q   <= {q[skf_pkg::GAIN_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // zero denominator means a gain of one
  assign quot      = (den == '0) ? skf_pkg::GAIN_ONE : q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hw/rtl/scalar_kalman_filter.sv]
// top level of the scalar kalman filter with sequencer and shared multiplier
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    sample (s32 q16.16), restart
//  out_ch    out  valid/ready    estimate (s32 q16.16), gain (u17 q1.16)
//  cfg       in   cfg_we         cfg_index, cfg_data (32 bits)
//
//  after the sample transfer the sequencer runs prediction, divider start, the gain divider
//  steps for all 17 quotient bits, quotient capture, two passes through the one 33x17
//  multiplier and the update, with which out_ch.valid rises
//  in_ch.ready is high only while the sequencer is idle
//  a waiting result holds the update step until out_ch takes it
//  rst is synchronous: q = 0, r = 1.0, estimate and covariance cleared
module scalar_kalman_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]        cfg_data,
  skf_in_if.sink                            in_ch,
  skf_out_if.source                         out_ch
);

  localparam int DW = skf_pkg::DATA_W;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int PW = skf_pkg::PROD_W;
  localparam int FW = skf_pkg::FRAC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRED = 3'd1;
  localparam logic [2:0] S_DST  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MULX = 3'd4;
  localparam logic [2:0] S_MULP = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  logic [2:0]            state;
  logic [DW-1:0]         q_noise;
  logic [DW-1:0]         r_noise;
  logic [DW-1:0]         est;
  logic [DW-1:0]         cov;
  logic [DW-1:0]         smp;
  logic                  restart_flag;
  logic [DW-1:0]         p_mid;
  logic [GW-1:0]         g;
  logic                  neg;
  logic [DW:0]           mag;
  logic [PW-1:0]         prod;
  logic [DW+1:0]         delta;
  logic                  out_valid;
  logic [DW-1:0]         out_est;
  logic [GW-1:0]         out_gain;

  logic [DW-1:0]         cov_eff;
  logic [DW-1:0]         x_eff;
  logic [DW:0]           p_sum;
  logic [DW-1:0]         p_sat;
  logic [DW:0]           innov;
  logic [DW:0]           mul_a;
  logic [GW-1:0]         mul_b;
  logic [PW-1:0]         rnd;
  logic [DW-1:0]         est_next;
  logic                  out_free;

  skf_pkg::skf_div_stat_t  div_stat;
  logic [GW-1:0]           div_quot;

  skf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DST),
    .num   (p_mid),
    .noise (r_noise),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // restart clears the state ahead of the prediction
  assign cov_eff = restart_flag ? '0 : cov;
  assign x_eff   = restart_flag ? '0 : est;
  assign p_sum   = {1'b0, cov_eff} + {1'b0, q_noise};
  assign p_sat   = p_sum[DW] ? '1 : p_sum[DW-1:0];
  assign innov   = {smp[DW-1], smp} - {x_eff[DW-1], x_eff};

  // one multiplier: gain * |innovation| first, then (1 - gain) * p
  assign mul_a = (state == S_MULX) ? mag : {1'b0, p_mid};
  assign mul_b = (state == S_MULX) ? g : (skf_pkg::GAIN_ONE - g);
  assign rnd   = prod + (PW'(1) << (FW - 1));

  assign est_next = neg ? (est - delta[DW-1:0]) : (est + delta[DW-1:0]);
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready     = (state == S_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.estimate = out_est;
  assign out_ch.gain     = out_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= '0;
      r_noise <= skf_pkg::R_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:     q_noise <= cfg_data;
        skf_pkg::REG_MEASUREMENT_NOISE: r_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      est       <= '0;
      cov       <= '0;
    end else begin
      if (state == S_UPD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= S_PRED;
          end
        end
        S_PRED: begin
          est   <= x_eff;
          state <= S_DST;
        end
        S_DST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_MULX;
          end
        end
        S_MULX: begin
          state <= S_MULP;
        end
        S_MULP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            est   <= est_next;
            cov   <= rnd[FW+DW-1:FW];
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      smp          <= in_ch.sample;
      restart_flag <= in_ch.restart;
    end
    if (state == S_PRED) begin
      p_mid <= p_sat;
      neg   <= innov[DW];
      mag   <= innov[DW] ? (~innov + (DW+1)'(1)) : innov;
    end
    if (state == S_DIV && div_stat.done) begin
      g <= div_quot;
    end
    if (state == S_MULX || state == S_MULP) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_MULP) begin
      delta <= rnd[PW-1:FW];
    end
    if (state == S_UPD && out_free) begin
      out_est  <= est_next;
      out_gain <= g;
    end
  end

endmodule

[hw/rtl/skf_checker.sv]
// port-level checks for the scalar kalman filter, bound to the top level
module skf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [skf_pkg::DATA_W-1:0]      out_estimate,
  input logic [skf_pkg::GAIN_W-1:0]      out_gain
);

  // gain is a fraction no larger than one
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_gain <= skf_pkg::GAIN_ONE))
    else $error("gain above one");

  // one sample at a time: the block is busy right after a transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a sample transfer");

  // no new result can appear the cycle after a sample is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared too early");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_estimate) && $stable(out_gain)))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_estimate (out_ch.estimate),
  .out_gain     (out_ch.gain)
);

[test/tb_top.sv]
// testbench for the scalar kalman filter: directed and random samples checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W    = skf_pkg::DATA_W;
  localparam int GAIN_W    = skf_pkg::GAIN_W;
  localparam int FRAC_W    = skf_pkg::FRAC_W;
  localparam int CFG_IDX_W = skf_pkg::CFG_IDX_W;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 195;

  class kalman_scoreboard;
    typedef struct {
      logic signed [DATA_W-1:0] estimate;
      logic [GAIN_W-1:0]        gain;
    } filter_out_t;

    logic [DATA_W-1:0]        q_var;
    logic [DATA_W-1:0]        r_var;
    logic signed [DATA_W-1:0] x_est;
    logic [DATA_W-1:0]        p_cov;
    filter_out_t              expected_out[$];
    int                       errors;

    function new();
      q_var  = '0;
      r_var  = skf_pkg::R_RESET;
      x_est  = '0;
      p_cov  = '0;
      errors = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] val);
      case (idx)
        skf_pkg::REG_PROCESS_NOISE:     q_var = val;
        skf_pkg::REG_MEASUREMENT_NOISE: r_var = val;
        default: ;
      endcase
    endfunction

    // a * g / 2^16, rounded half up
    function bit [63:0] scale_q16(input bit [63:0] a, input bit [63:0] g);
      return (a * g + 64'h8000) >> 16;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    // advance the filter by one accepted sample and queue the result it must produce
    function void note_sample(input logic signed [DATA_W-1:0] z, input logic rs);
      bit [DATA_W:0] p_pred;
      bit [63:0]     den;
      bit [63:0]     k;
      bit [63:0]     mag;
      bit [63:0]     delta;
      bit [63:0]     p_next;
      longint        innov;
      longint        x_next;
      filter_out_t   res;
      if (rs) begin
        x_est = '0;
        p_cov = '0;
      end
      p_pred = {1'b0, p_cov} + {1'b0, q_var};
      if (p_pred[DATA_W]) p_pred = {1'b0, {DATA_W{1'b1}}};
      den = 64'(p_pred) + 64'(r_var);
      if (den == 0) k = 64'(skf_pkg::GAIN_ONE);
      else k = (64'(p_pred) << FRAC_W) / den;
      if (k > 64'(skf_pkg::GAIN_ONE)) k = 64'(skf_pkg::GAIN_ONE);
      innov = longint'(z) - longint'(x_est);
      mag = (innov < 0) ? 64'(-innov) : 64'(innov);
      delta = scale_q16(mag, k);
      x_next = (innov < 0) ? longint'(x_est) - longint'(delta) : longint'(x_est) + longint'(delta);
      p_next = scale_q16(64'(p_pred), 64'(skf_pkg::GAIN_ONE) - k);
      x_est = x_next[DATA_W-1:0];
      p_cov = p_next[DATA_W-1:0];
      res.estimate = x_est;
      res.gain     = k[GAIN_W-1:0];
      expected_out.push_back(res);
    endfunction

    function void check_result(input logic signed [DATA_W-1:0] est, input logic [GAIN_W-1:0] g);
      filter_out_t res;
      if (expected_out.size() == 0) begin
        $error("unexpected result: estimate %0d gain %0d", est, g);
        errors++;
        return;
      end
      res = expected_out.pop_front();
      if (est !== res.estimate) begin
        $error("estimate: expected %0d, actual %0d", res.estimate, est);
        errors++;
      end
      if (g !== res.gain) begin
        $error("gain: expected %0d, actual %0d", res.gain, g);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  bit                   steady = 1'b0;
  int                   idle_cycles = 0;

  skf_in_if  in_ch ();
  skf_out_if out_ch ();

  kalman_scoreboard sb = new();

  scalar_kalman_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // result side: check each transfer, stall at random outside the steady stretch
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.estimate, out_ch.gain);
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic feed(input logic signed [DATA_W-1:0] s, input logic rs);
    if (!steady && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s, rs);
  endtask

  // hold off input until every result is out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_noise(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= skf_pkg::REG_PROCESS_NOISE;
    cfg_data  <= q;
    @(posedge clk);
    sb.write_reg(skf_pkg::REG_PROCESS_NOISE, q);
    cfg_index <= skf_pkg::REG_MEASUREMENT_NOISE;
    cfg_data  <= r;
    @(posedge clk);
    sb.write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r);
    cfg_we <= 1'b0;
  endtask

  // mix of full-range noise, extremes and readings around a slowly moving center
  function automatic logic signed [DATA_W-1:0] pick_sample(
      input logic signed [DATA_W-1:0] center);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom;
    if (sel < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return center + $signed($urandom_range(0, 131072)) - 32'sd65536;
  endfunction

  initial begin
    logic [DATA_W-1:0]        q_val;
    logic [DATA_W-1:0]        r_val;
    logic signed [DATA_W-1:0] center;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= skf_pkg::REG_PROCESS_NOISE;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no process noise, so the gain stays zero
    feed(32'sh7FFF_FFFF, 1'b0);
    feed(32'sh8000_0000, 1'b1);

    // zero denominator: gain of one, estimate follows the sample
    settle();
    set_noise('0, '0);
    feed(32'sh7FFF_FFFF, 1'b1);
    feed(32'sh8000_0000, 1'b0);
    feed(32'sh0000_0000, 1'b0);
    feed(-32'sd1, 1'b0);
    feed(32'sh0000_0001, 1'b1);

    // both noises at the top: gain of one half, odd innovations hit the rounding tie
    settle();
    set_noise('1, '1);
    feed(32'sh7FFF_FFFF, 1'b1);
    feed(32'sh8000_0000, 1'b0);
    feed(32'sh1234_5677, 1'b0);
    feed(32'sh8000_0000, 1'b1);

    // saturated prediction with no measurement noise
    settle();
    set_noise('1, '0);
    feed(32'sh7FFF_FFFF, 1'b0);
    feed(32'sh8000_0000, 1'b0);

    settle();
    set_noise(32'h0001_0000, 32'h0001_0000);
    feed(32'sh0001_0000, 1'b1);
    feed(32'sh0002_0000, 1'b0);
    feed(-32'sh0003_8000, 1'b0);
    feed(32'sh0000_0000, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin q_val = 32'h0000_0400; r_val = 32'h0004_0000; end
        1: begin q_val = $urandom;      r_val = $urandom;      end
        2: begin q_val = $urandom_range(0, 32'h0002_0000); r_val = $urandom >> 8; end
        3: begin q_val = '0;            r_val = '0;            end
        4: begin q_val = '1;            r_val = $urandom;      end
        5: begin q_val = $urandom >> 8; r_val = $urandom >> 4; end
        default: begin q_val = '0;      r_val = '1;            end
      endcase
      set_noise(q_val, r_val);
      steady = (ph == 2);
      center = $urandom;
      repeat (PHASE_ITEMS) begin
        feed(pick_sample(center), $urandom_range(0, 99) < 3);
        if ($urandom_range(0, 9) == 0) center = center + $signed($urandom_range(0, 8192)) - 4096;
      end
    end
    steady = 1'b0;

    settle();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/skf_pkg.sv
hw/rtl/skf_in_if.sv
hw/rtl/skf_out_if.sv
hw/rtl/skf_div.sv
hw/rtl/scalar_kalman_filter.sv
hw/rtl/skf_checker.sv
test/tb_top.sv
